/* src/dependency_graph_layering_core_macros.svh */
// ----------------------------------------------------------------------------
// dependency graph layering assertion macros
// simulation-only property checks, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_GRAPH_LAYERING_CORE_MACROS_SVH
`define DEPENDENCY_GRAPH_LAYERING_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication under clk_i and rst_ni
`define DGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dgl assertion failed");
// next-cycle implication under clk_i and rst_ni
`define DGL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dgl assertion failed");
`else
`define DGL_ASSERT_IMP(lbl, ante, cons)
`define DGL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/dgl_pkg.sv */
// ----------------------------------------------------------------------------
// dgl_pkg
// shared types, constants and helpers of the dependency graph layering core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgl_pkg;

  localparam int unsigned NumStages = 32;
  localparam int unsigned IdxW      = $clog2(NumStages);
  localparam int unsigned RankW     = 5;

  typedef enum logic [1:0] {
    CMD_ADD_STAGE = 2'd0,
    CMD_ADD_EDGE  = 2'd1,
    CMD_COMPILE   = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_CYCLE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_CHK,
    S_REACH_ISSUE,
    S_REACH_WAIT,
    S_RESULT,
    S_SWEEP,
    S_EMIT
  } state_e;

  typedef logic [NumStages-1:0] row_t;
  typedef logic [IdxW-1:0]      idx_t;

  // index of the lowest set bit, zero when none
  function automatic idx_t lowest_idx(row_t v);
    idx_t r;
    r = '0;
    for (int i = NumStages - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = idx_t'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/dgl_if.sv */
// ----------------------------------------------------------------------------
// dgl channel interfaces
// command channel and result channel with valid / ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dgl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] from_stage;
  logic [4:0] to_stage;

  modport source (output valid, command, from_stage, to_stage, input ready);
  modport sink   (input valid, command, from_stage, to_stage, output ready);
endinterface

interface dgl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] stage;
  logic [4:0] rank;
  logic       empty_graph;
  logic       last;

  modport source (output valid, status, stage, rank, empty_graph, last, input ready);
  modport sink   (input valid, status, stage, rank, empty_graph, last, output ready);
endinterface

/* src/dependency_graph_layering_core.sv */
// ----------------------------------------------------------------------------
// dependency_graph_layering_core
// acyclic stage ordering graph with cycle refusal and rank-ordered compile
// ----------------------------------------------------------------------------
// Items are handled one at a time; the core takes a new item once the previous
// one has been worked off, while its last result may still sit in the output
// register. Adjacency rows live in a 32x32 ram with a registered read port.
// Add stage and the unused command go straight to the result. Add ordering
// reads the row of the source stage and answers a repeated edge without a
// search; otherwise it reads one row per stage visited from the destination
// during the cycle search. Compile peels the graph one rank at a time: each
// rank reads the rows of all stages not yet reported, then reports that rank's
// stages one a cycle while the output is not stalled. Presence bits and a
// per-row written flag are flip-flops cleared by reset; the ram itself needs
// no clearing, since a row never written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dependency_graph_layering_core_macros.svh"

module dependency_graph_layering_core
  import dgl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  dgl_in_if.sink       in_i,
  dgl_out_if.source    out_o
);

  state_e state_q, state_d;

  row_t    present_q, present_d;
  row_t    written_q, written_d;
  row_t    reach_q, reach_d;
  row_t    visited_q, visited_d;
  row_t    row_q, row_d;
  row_t    pending_q, pending_d;
  row_t    incoming_q, incoming_d;
  row_t    remain_q, remain_d;
  row_t    layer_q, layer_d;
  idx_t    from_q, from_d;
  idx_t    to_q, to_d;
  logic [RankW-1:0] lvl_q, lvl_d;
  status_e res_status_q, res_status_d;
  logic    res_empty_q, res_empty_d;
  logic    rd_vld_q, rd_vld_d;
  logic    rd_ok_q;

  logic             ovld_q, ovld_d;
  logic [1:0]       ostatus_q, ostatus_d;
  logic [IdxW-1:0]  ostage_q, ostage_d;
  logic [RankW-1:0] orank_q, orank_d;
  logic             oempty_q, oempty_d;
  logic             olast_q, olast_d;

  logic  rd_en, wr_en;
  idx_t  rd_addr;
  row_t  rd_data, rd_row, wr_data;
  logic  out_free, in_acc;
  row_t  frontier, layer_rest, remain_rest;
  idx_t  pick;

  assign out_free = !ovld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;

  // a row never written reads as zero
  assign rd_row = rd_ok_q ? rd_data : '0;

  assign frontier    = reach_q & ~visited_q;
  assign pick        = lowest_idx(layer_q);
  assign layer_rest  = layer_q & ~(row_t'(1) << pick);
  assign remain_rest = remain_q & ~(row_t'(1) << pick);

  dgl_ram #(
    .Depth (NumStages),
    .Width (NumStages)
  ) u_rows (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (from_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_e'(in_i.command))
            CMD_ADD_EDGE: state_d = S_EDGE_CHK;
            CMD_COMPILE:  state_d = (present_q == '0) ? S_RESULT : S_SWEEP;
            default:      state_d = S_RESULT;
          endcase
        end
      end
      S_EDGE_CHK: state_d = rd_row[to_q] ? S_RESULT : S_REACH_ISSUE;
      S_REACH_ISSUE: begin
        if (reach_q[from_q] || frontier == '0) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_REACH_WAIT;
        end
      end
      S_REACH_WAIT: state_d = S_REACH_ISSUE;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (pending_q == '0 && !rd_vld_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && layer_rest == '0) begin
          state_d = (remain_rest == '0) ? S_IDLE : S_SWEEP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    present_d    = present_q;
    written_d    = written_q;
    reach_d      = reach_q;
    visited_d    = visited_q;
    row_d        = row_q;
    pending_d    = pending_q;
    incoming_d   = incoming_q;
    remain_d     = remain_q;
    layer_d      = layer_q;
    from_d       = from_q;
    to_d         = to_q;
    lvl_d        = lvl_q;
    res_status_d = res_status_q;
    res_empty_d  = res_empty_q;
    rd_vld_d     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = from_q;
    wr_en        = 1'b0;
    wr_data      = row_q | (row_t'(1) << to_q);
    ovld_d       = ovld_q && !out_o.ready;
    ostatus_d    = ostatus_q;
    ostage_d     = ostage_q;
    orank_d      = orank_q;
    oempty_d     = oempty_q;
    olast_d      = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          from_d      = in_i.from_stage;
          to_d        = in_i.to_stage;
          res_empty_d = 1'b0;
          unique case (cmd_e'(in_i.command))
            CMD_ADD_STAGE: begin
              res_status_d = present_q[in_i.from_stage] ? ST_PRESENT : ST_DONE;
              present_d[in_i.from_stage] = 1'b1;
            end
            CMD_ADD_EDGE: begin
              present_d[in_i.from_stage] = 1'b1;
              present_d[in_i.to_stage]   = 1'b1;
              rd_en   = 1'b1;
              rd_addr = in_i.from_stage;
            end
            CMD_COMPILE: begin
              res_status_d = ST_DONE;
              res_empty_d  = 1'b1;
              remain_d     = present_q;
              pending_d    = present_q;
              incoming_d   = '0;
              lvl_d        = '0;
            end
            default: res_status_d = ST_PRESENT;
          endcase
        end
      end
      S_EDGE_CHK: begin
        row_d        = rd_row;
        res_status_d = ST_PRESENT;
        reach_d      = row_t'(1) << to_q;
        visited_d    = '0;
      end
      S_REACH_ISSUE: begin
        if (reach_q[from_q]) begin
          res_status_d = ST_CYCLE;
        end else if (frontier == '0) begin
          res_status_d      = ST_DONE;
          wr_en             = 1'b1;
          written_d[from_q] = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lowest_idx(frontier);
          visited_d = visited_q | (row_t'(1) << lowest_idx(frontier));
        end
      end
      S_REACH_WAIT: reach_d = reach_q | rd_row;
      S_RESULT: begin
        if (out_free) begin
          ovld_d    = 1'b1;
          ostatus_d = res_status_q;
          ostage_d  = '0;
          orank_d   = '0;
          oempty_d  = res_empty_q;
          olast_d   = 1'b1;
        end
      end
      S_SWEEP: begin
        if (pending_q != '0) begin
          rd_en     = 1'b1;
          rd_addr   = lowest_idx(pending_q);
          pending_d = pending_q & ~(row_t'(1) << lowest_idx(pending_q));
          rd_vld_d  = 1'b1;
        end
        if (rd_vld_q) begin
          incoming_d = incoming_q | rd_row;
        end else if (pending_q == '0) begin
          // stages left with no edge from any remaining stage form this rank
          layer_d = remain_q & ~incoming_q;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovld_d    = 1'b1;
          ostatus_d = ST_DONE;
          ostage_d  = pick;
          orank_d   = lvl_q;
          oempty_d  = 1'b0;
          olast_d   = (remain_rest == '0);
          layer_d   = layer_rest;
          remain_d  = remain_rest;
          if (layer_rest == '0) begin
            lvl_d      = lvl_q + RankW'(1);
            pending_d  = remain_rest;
            incoming_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      present_q <= '0;
      written_q <= '0;
      rd_vld_q  <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      written_q <= written_d;
      rd_vld_q  <= rd_vld_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_ok_q <= written_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    reach_q      <= reach_d;
    visited_q    <= visited_d;
    row_q        <= row_d;
    pending_q    <= pending_d;
    incoming_q   <= incoming_d;
    remain_q     <= remain_d;
    layer_q      <= layer_d;
    from_q       <= from_d;
    to_q         <= to_d;
    lvl_q        <= lvl_d;
    res_status_q <= res_status_d;
    res_empty_q  <= res_empty_d;
    ostatus_q    <= ostatus_d;
    ostage_q     <= ostage_d;
    orank_q      <= orank_d;
    oempty_q     <= oempty_d;
    olast_q      <= olast_d;
  end

  assign out_o.valid       = ovld_q;
  assign out_o.status      = ostatus_q;
  assign out_o.stage       = ostage_q;
  assign out_o.rank        = orank_q;
  assign out_o.empty_graph = oempty_q;
  assign out_o.last        = olast_q;

  `DGL_ASSERT_IMP(a_no_cycle_write, wr_en, !reach_q[from_q] && !row_q[to_q])
  `DGL_ASSERT_IMP(a_layer_nonempty, state_q == S_EMIT, layer_q != '0)
  `DGL_ASSERT_IMP(a_layer_in_remain, state_q == S_EMIT, (layer_q & ~remain_q) == '0)
  `DGL_ASSERT_NXT(a_no_read_overlap, wr_en, !rd_vld_q && state_q == S_RESULT)

endmodule

/* src/dgl_ram.sv */
// ----------------------------------------------------------------------------
// dgl_ram
// single-port-write, single-port-read synchronous ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgl_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
